// File: rtl/core/bptc_pkg.sv
// shared types and constants of the barometer compensation block
package bptc_pkg;

    // number of register stages in the compensation pipeline
    localparam int unsigned N_STAGE = 8;

    // configuration register indexes
    localparam logic [2:0] REG_SENS_COEFF    = 3'd0;
    localparam logic [2:0] REG_OFF_COEFF     = 3'd1;
    localparam logic [2:0] REG_SENS_TEMPCO   = 3'd2;
    localparam logic [2:0] REG_OFF_TEMPCO    = 3'd3;
    localparam logic [2:0] REG_REF_TEMP_WORD = 3'd4;
    localparam logic [2:0] REG_TEMP_SLOPE    = 3'd5;
    localparam logic [2:0] REG_LAST          = REG_TEMP_SLOPE;

    // temperature thresholds in 0.01 C
    localparam logic signed [18:0] TEMP_REF   = 19'sd2000;
    localparam logic signed [18:0] TEMP_VCOLD = -19'sd1500;

    typedef struct packed {
        logic [15:0] sens_coeff;
        logic [15:0] off_coeff;
        logic [15:0] sens_tempco;
        logic [15:0] off_tempco;
        logic [15:0] ref_temp_word;
        logic [15:0] temp_slope;
    } t_cal;

endpackage

// File: rtl/core/bptc_datapath.sv
// eight-stage arithmetic datapath of the barometer compensation
module bptc_datapath (
    input  logic                              i_clk,
    input  logic [bptc_pkg::N_STAGE-1:0]      i_en,
    input  bptc_pkg::t_cal                    i_cal,
    input  logic [23:0]                       i_raw_pressure,
    input  logic [23:0]                       i_raw_temperature,
    output logic signed [31:0]                o_temperature,
    output logic signed [31:0]                o_pressure
);

    // stage 1: temperature difference
    logic signed [24:0] n_dt;
    logic signed [24:0] r1_dt;
    logic [23:0]        r1_d1;

    assign n_dt = $signed({1'b0, i_raw_temperature})
                - $signed({1'b0, i_cal.ref_temp_word, 8'h00});

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_dt <= n_dt;
            r1_d1 <= i_raw_pressure;
        end
    end

    // stage 2: products with dt
    logic signed [41:0] n_p_t;
    logic signed [41:0] n_p_off;
    logic signed [41:0] n_p_sens;
    logic signed [49:0] n_p_dd;
    logic signed [41:0] r2_p_t;
    logic signed [41:0] r2_p_off;
    logic signed [41:0] r2_p_sens;
    logic [47:0]        r2_p_dd;
    logic [23:0]        r2_d1;

    assign n_p_t    = r1_dt * $signed({1'b0, i_cal.temp_slope});
    assign n_p_off  = r1_dt * $signed({1'b0, i_cal.off_tempco});
    assign n_p_sens = r1_dt * $signed({1'b0, i_cal.sens_tempco});
    assign n_p_dd   = r1_dt * r1_dt;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_p_t    <= n_p_t;
            r2_p_off  <= n_p_off;
            r2_p_sens <= n_p_sens;
            r2_p_dd   <= n_p_dd[47:0];
            r2_d1     <= r1_d1;
        end
    end

    // stage 3: first-order temp, off, sens; divisions round toward zero
    logic signed [41:0] n_t_div;
    logic signed [41:0] n_off_div;
    logic signed [41:0] n_sens_div;
    logic signed [18:0] n_temp1;
    logic signed [35:0] n_off;
    logic signed [35:0] n_sens;
    logic signed [18:0] r3_temp;
    logic signed [35:0] r3_off;
    logic signed [35:0] r3_sens;
    logic [17:0]        r3_t2;
    logic [23:0]        r3_d1;

    assign n_t_div    = (r2_p_t + (r2_p_t[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
    assign n_off_div  = (r2_p_off + (r2_p_off[41] ? 42'sd63 : 42'sd0)) >>> 6;
    assign n_sens_div = (r2_p_sens + (r2_p_sens[41] ? 42'sd127 : 42'sd0)) >>> 7;
    assign n_temp1    = 19'(n_t_div) + bptc_pkg::TEMP_REF;
    assign n_off      = $signed({3'b000, i_cal.off_coeff, 17'd0}) + 36'(n_off_div);
    assign n_sens     = $signed({4'h0, i_cal.sens_coeff, 16'h0000}) + 36'(n_sens_div);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_temp <= n_temp1;
            r3_off  <= n_off;
            r3_sens <= n_sens;
            r3_t2   <= {1'b0, r2_p_dd[47:31]};
            r3_d1   <= r2_d1;
        end
    end

    // stage 4: squares for the second-order correction
    logic signed [17:0] n_q;
    logic signed [18:0] n_r;
    logic signed [35:0] n_sq_q;
    logic signed [37:0] n_sq_r;
    logic [34:0]        r4_sq_q;
    logic [34:0]        r4_sq_r;
    logic               r4_cold;
    logic               r4_vcold;
    logic signed [18:0] r4_temp;
    logic signed [35:0] r4_off;
    logic signed [35:0] r4_sens;
    logic [17:0]        r4_t2;
    logic [23:0]        r4_d1;

    assign n_q    = 18'(r3_temp - bptc_pkg::TEMP_REF);
    assign n_r    = r3_temp - bptc_pkg::TEMP_VCOLD;
    assign n_sq_q = n_q * n_q;
    assign n_sq_r = n_r * n_r;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_sq_q  <= n_sq_q[34:0];
            r4_sq_r  <= n_sq_r[34:0];
            r4_cold  <= (r3_temp < bptc_pkg::TEMP_REF);
            r4_vcold <= (r3_temp < bptc_pkg::TEMP_VCOLD);
            r4_temp  <= r3_temp;
            r4_off   <= r3_off;
            r4_sens  <= r3_sens;
            r4_t2    <= r3_t2;
            r4_d1    <= r3_d1;
        end
    end

    // stage 5: apply second-order terms (all terms non-negative, so shifts)
    logic [37:0]        n_five_q;
    logic [37:0]        n_seven_r;
    logic [38:0]        n_eleven_r;
    logic [38:0]        n_off2;
    logic [38:0]        n_sens2;
    logic signed [40:0] n_off_f;
    logic signed [40:0] n_sens_f;
    logic signed [19:0] n_temp_f;
    logic signed [40:0] r5_off;
    logic signed [40:0] r5_sens;
    logic signed [19:0] r5_temp;
    logic [23:0]        r5_d1;

    assign n_five_q   = {1'b0, r4_sq_q, 2'b00} + {3'b000, r4_sq_q};
    assign n_seven_r  = {r4_sq_r, 3'b000} - {3'b000, r4_sq_r};
    assign n_eleven_r = {1'b0, r4_sq_r, 3'b000} + {3'b000, r4_sq_r, 1'b0}
                      + {4'h0, r4_sq_r};
    assign n_off2     = {2'b00, n_five_q[37:1]}
                      + (r4_vcold ? {1'b0, n_seven_r} : 39'd0);
    assign n_sens2    = {3'b000, n_five_q[37:2]}
                      + (r4_vcold ? {1'b0, n_eleven_r[38:1]} : 39'd0);
    assign n_off_f    = 41'(r4_off) - (r4_cold ? $signed({2'b00, n_off2}) : 41'sd0);
    assign n_sens_f   = 41'(r4_sens) - (r4_cold ? $signed({2'b00, n_sens2}) : 41'sd0);
    assign n_temp_f   = 20'(r4_temp) - (r4_cold ? $signed({2'b00, r4_t2}) : 20'sd0);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_off  <= n_off_f;
            r5_sens <= n_sens_f;
            r5_temp <= n_temp_f;
            r5_d1   <= r4_d1;
        end
    end

    // stage 6: d1 * sens as two partial products
    logic [43:0]        n_pp_lo;
    logic signed [45:0] n_pp_hi;
    logic [43:0]        r6_pp_lo;
    logic signed [45:0] r6_pp_hi;
    logic signed [40:0] r6_off;
    logic signed [19:0] r6_temp;

    assign n_pp_lo = r5_d1 * r5_sens[19:0];
    assign n_pp_hi = $signed({1'b0, r5_d1}) * $signed(r5_sens[40:20]);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r6_pp_lo <= n_pp_lo;
            r6_pp_hi <= n_pp_hi;
            r6_off   <= r5_off;
            r6_temp  <= r5_temp;
        end
    end

    // stage 7: combine product, divide by 2^21, subtract offset
    logic signed [64:0] n_prod;
    logic signed [64:0] n_prod_div;
    logic signed [44:0] n_x;
    logic signed [44:0] r7_x;
    logic signed [19:0] r7_temp;

    assign n_prod     = (65'(r6_pp_hi) <<< 20) + $signed({21'd0, r6_pp_lo});
    assign n_prod_div = (n_prod + (n_prod[64] ? 65'sd2097151 : 65'sd0)) >>> 21;
    assign n_x        = 45'(n_prod_div) - 45'(r6_off);

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r7_x    <= n_x;
            r7_temp <= r6_temp;
        end
    end

    // stage 8: divide by 2^15 into the output register
    logic signed [44:0] n_p_div;
    logic signed [31:0] r8_temperature;
    logic signed [31:0] r8_pressure;

    assign n_p_div = (r7_x + (r7_x[44] ? 45'sd32767 : 45'sd0)) >>> 15;

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r8_temperature <= 32'(r7_temp);
            r8_pressure    <= 32'(n_p_div);
        end
    end

    assign o_temperature = r8_temperature;
    assign o_pressure    = r8_pressure;

endmodule

// File: rtl/core/baro_pressure_temp_compensation.sv
// top level of the barometer pressure and temperature compensation pipeline
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------------
//  input    | in        | i_valid / o_ready          | i_raw_pressure, i_raw_temperature
//  result   | out       | o_valid / i_ready          | o_temperature, o_pressure
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one conversion pair per cycle while the result side is not stalled; each result
// passes through the eight register stages of the datapath, the widest being the
// split d1 * sens multiply and its recombination
// reset clears the stage valid bits and all six calibration words
// a stall on the result side holds only the occupied stages with no empty stage after
// them; the rest still advance, so bubbles are squeezed out and nothing is lost or repeated
module baro_pressure_temp_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [23:0]        i_raw_pressure,
    input  logic [23:0]        i_raw_temperature,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_temperature,
    output logic signed [31:0] o_pressure,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int unsigned NS = bptc_pkg::N_STAGE;

    // calibration words
    bptc_pkg::t_cal r_cal;

    // one valid bit per pipeline stage
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;

    // config writes are always taken; out-of-range indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bptc_pkg::REG_SENS_COEFF:    r_cal.sens_coeff    <= i_cfg_data;
                bptc_pkg::REG_OFF_COEFF:     r_cal.off_coeff     <= i_cfg_data;
                bptc_pkg::REG_SENS_TEMPCO:   r_cal.sens_tempco   <= i_cfg_data;
                bptc_pkg::REG_OFF_TEMPCO:    r_cal.off_tempco    <= i_cfg_data;
                bptc_pkg::REG_REF_TEMP_WORD: r_cal.ref_temp_word <= i_cfg_data;
                bptc_pkg::REG_TEMP_SLOPE:    r_cal.temp_slope    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a stage may load when it is empty or when the stage after it moves on
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NS-1];

    bptc_datapath u_datapath (
        .i_clk             (i_clk),
        .i_en              (w_en),
        .i_cal             (r_cal),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_temperature     (o_temperature),
        .o_pressure        (o_pressure)
    );

`ifndef SYNTHESIS
    // a free output slot always lets the input side in
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input stalled although the pipeline can advance");

    // occupancy grows by one for an accepted input with no result taken
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !(o_valid && i_ready))
        |=> ($countones(r_vld) == $past($countones(r_vld)) + 1))
        else $error("pipeline occupancy lost or duplicated a transaction");

    // occupancy shrinks by one for a taken result with no new input
    a_drain_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(i_valid && o_ready) && o_valid && i_ready)
        |=> ($countones(r_vld) + 1 == $past($countones(r_vld))))
        else $error("pipeline drain lost or duplicated a transaction");

    // a write beyond the register list leaves calibration untouched
    a_cfg_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && (i_cfg_index > bptc_pkg::REG_LAST))
        |=> $stable(r_cal))
        else $error("out-of-range config write changed calibration");
`endif

endmodule

// File: tb/baro_pressure_temp_compensation_tb.sv
// testbench of the barometer compensation pipeline: calibration phases, conversions, checks
module baro_pressure_temp_compensation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no transaction on any channel before the run is declared hung
    localparam int QUIET_LIMIT = 2000;

    // the two indexes that the 3-bit register field can carry but that map to nothing
    localparam logic [2:0] REG_UNMAPPED_LO = bptc_pkg::REG_LAST + 3'd1;
    localparam logic [2:0] REG_UNMAPPED_HI = bptc_pkg::REG_LAST + 3'd2;

    // temperature thresholds widened to the 64-bit arithmetic of the predictor
    localparam longint T_REF   = bptc_pkg::TEMP_REF;
    localparam longint T_VCOLD = bptc_pkg::TEMP_VCOLD;

    // calibration words of a typical part, nominal reading lands near 20 C
    localparam bptc_pkg::t_cal DATASHEET_CAL = '{
        sens_coeff:    16'd40127,
        off_coeff:     16'd36924,
        sens_tempco:   16'd23317,
        off_tempco:    16'd23282,
        ref_temp_word: 16'd33464,
        temp_slope:    16'd28312
    };

    typedef struct {
        logic signed [31:0] temp_c;
        logic signed [31:0] press_mbar;
    } t_reading;

    // compensation predictor plus the readings owed by the pipeline, oldest first
    class compensated_readings;
        bptc_pkg::t_cal cal = '0;
        t_reading       due[$];
        int             n_mismatch = 0;

        function void write_cal(logic [2:0] idx, logic [15:0] data);
            case (idx)
                bptc_pkg::REG_SENS_COEFF:    cal.sens_coeff    = data;
                bptc_pkg::REG_OFF_COEFF:     cal.off_coeff     = data;
                bptc_pkg::REG_SENS_TEMPCO:   cal.sens_tempco   = data;
                bptc_pkg::REG_OFF_TEMPCO:    cal.off_tempco    = data;
                bptc_pkg::REG_REF_TEMP_WORD: cal.ref_temp_word = data;
                bptc_pkg::REG_TEMP_SLOPE:    cal.temp_slope    = data;
                default: ;
            endcase
        endfunction

        function t_reading compensate(logic [23:0] raw_p, logic [23:0] raw_t);
            longint c1, c2, c3, c4, c5, c6;
            longint d1, d2, dt, temp, off, sens, t2, warm, cold, off2, sens2, p;
            t_reading r;
            c1 = cal.sens_coeff;
            c2 = cal.off_coeff;
            c3 = cal.sens_tempco;
            c4 = cal.off_tempco;
            c5 = cal.ref_temp_word;
            c6 = cal.temp_slope;
            d1 = raw_p;
            d2 = raw_t;
            // every division truncates toward zero, as signed / does
            dt   = d2 - c5 * 256;
            temp = T_REF + (dt * c6) / 8388608;
            off  = c2 * 131072 + (c4 * dt) / 64;
            sens = c1 * 65536 + (c3 * dt) / 128;
            if (temp < T_REF) begin
                // second order terms all use the first order temperature
                t2    = (dt * dt) / 64'sd2147483648;
                warm  = (temp - T_REF) * (temp - T_REF);
                off2  = (5 * warm) / 2;
                sens2 = (5 * warm) / 4;
                if (temp < T_VCOLD) begin
                    cold  = (temp - T_VCOLD) * (temp - T_VCOLD);
                    off2  = off2 + 7 * cold;
                    sens2 = sens2 + (11 * cold) / 2;
                end
                temp = temp - t2;
                off  = off - off2;
                sens = sens - sens2;
            end
            p = ((d1 * sens) / 2097152 - off) / 32768;
            // results wrap to 32 bits
            r.temp_c     = temp[31:0];
            r.press_mbar = p[31:0];
            return r;
        endfunction

        function void note_conversion(logic [23:0] raw_p, logic [23:0] raw_t);
            due.push_back(compensate(raw_p, raw_t));
        endfunction

        function void check_reading(logic signed [31:0] temp_c, logic signed [31:0] press_mbar);
            t_reading want;
            if (due.size() == 0) begin
                $error("result with none outstanding: temperature %0d, pressure %0d",
                       temp_c, press_mbar);
                n_mismatch++;
                return;
            end
            want = due.pop_front();
            if (temp_c !== want.temp_c) begin
                $error("temperature: expected %0d, got %0d", want.temp_c, temp_c);
                n_mismatch++;
            end
            if (press_mbar !== want.press_mbar) begin
                $error("pressure: expected %0d, got %0d", want.press_mbar, press_mbar);
                n_mismatch++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [23:0]        i_raw_pressure = '0;
    logic [23:0]        i_raw_temperature = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_temperature;
    logic signed [31:0] o_pressure;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    compensated_readings readings = new;

    // while set, neither side inserts idle cycles
    bit steady = 1'b0;
    int quiet_cycles = 0;

    baro_pressure_temp_compensation u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_temperature     (o_temperature),
        .o_pressure        (o_pressure),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // result side: random back-pressure, and every accepted result checked in order
    always @(posedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= 14);
        if (i_rst_n && o_valid && i_ready)
            readings.check_reading(o_temperature, o_pressure);
    end

    // hang detection: any transaction on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one conversion pair; valid is left high so the next pair can follow back to back
    task automatic send_conversion(input logic [23:0] d1, input logic [23:0] d2);
        if (!steady && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_raw_pressure    <= d1;
        i_raw_temperature <= d2;
        do @(posedge i_clk); while (!o_ready);
        readings.note_conversion(d1, d2);
    endtask

    // random pair: a third anywhere, a third just above the reference temperature and
    // a third below it over a much wider span, so both correction ranges get plenty of hits
    task automatic send_random(input bptc_pkg::t_cal c);
        logic [23:0] d1;
        logic [23:0] d2;
        logic [23:0] ref_raw;
        d1      = 24'($urandom);
        ref_raw = {c.ref_temp_word, 8'd0};
        case ($urandom_range(2))
            0:       d2 = 24'($urandom);
            1:       d2 = ref_raw - 24'($urandom_range(0, 1 << 21));
            default: d2 = ref_raw + 24'($urandom_range(0, 1 << 16));
        endcase
        send_conversion(d1, d2);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        readings.write_cal(idx, data);
    endtask

    // all six words, then a stray write to an unmapped index that must change nothing
    task automatic program_cal(input bptc_pkg::t_cal c);
        write_reg(bptc_pkg::REG_SENS_COEFF, c.sens_coeff);
        write_reg(bptc_pkg::REG_OFF_COEFF, c.off_coeff);
        write_reg(bptc_pkg::REG_SENS_TEMPCO, c.sens_tempco);
        write_reg(bptc_pkg::REG_OFF_TEMPCO, c.off_tempco);
        write_reg(bptc_pkg::REG_REF_TEMP_WORD, c.ref_temp_word);
        write_reg(bptc_pkg::REG_TEMP_SLOPE, c.temp_slope);
        write_reg(($urandom_range(1) != 0) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                  16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending and let every owed reading come out before touching the registers
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (readings.due.size() != 0) @(posedge i_clk);
        repeat (bptc_pkg::N_STAGE + 2) @(posedge i_clk);
    endtask

    initial begin
        bptc_pkg::t_cal cal;
        int             n_items;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // calibration straight out of reset is all zero
        send_conversion(24'hFFFFFF, 24'hFFFFFF);
        send_conversion(24'h123456, 24'h000000);
        drain_pipeline();

        // directed pairs on typical calibration
        program_cal(DATASHEET_CAL);
        send_conversion(24'd9085466, 24'd8569150);   // nominal reading
        send_conversion(24'h000000, 24'h000000);
        send_conversion(24'hFFFFFF, 24'hFFFFFF);
        send_conversion(24'h000000, 24'hFFFFFF);
        send_conversion(24'hFFFFFF, 24'h000000);
        send_conversion(24'hAAAAAA, 24'h555555);
        send_conversion(24'h555555, 24'hAAAAAA);
        send_conversion(24'd9085466, 24'd8566488);   // exactly 20.00 C, no correction
        send_conversion(24'd9085466, 24'd8566487);   // 19.99 C, cold range starts
        send_conversion(24'd9085466, 24'd8000000);   // well inside the cold range
        send_conversion(24'd9085466, 24'd7529468);   // exactly -15.00 C, no extra term
        send_conversion(24'd9085466, 24'd7529467);   // -15.01 C, very cold term starts
        send_conversion(24'd9085466, 24'd6000000);   // deep in the very cold range
        drain_pipeline();

        // random phases: typical, all ones, all zeros, then random calibration;
        // the fourth phase runs without any idling on either side
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: cal = DATASHEET_CAL;
                1: cal = '1;
                2: cal = '0;
                default: begin
                    cal.sens_coeff    = 16'($urandom);
                    cal.off_coeff     = 16'($urandom);
                    cal.sens_tempco   = 16'($urandom);
                    cal.off_tempco    = 16'($urandom);
                    cal.ref_temp_word = 16'($urandom);
                    cal.temp_slope    = 16'($urandom);
                end
            endcase
            steady  = (ph == 3);
            n_items = (ph == 2) ? 40 : 100;
            program_cal(cal);
            repeat (n_items) send_random(cal);
            drain_pipeline();
        end

        if (readings.n_mismatch == 0 && readings.due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/bptc_pkg.sv
rtl/core/bptc_datapath.sv
rtl/core/baro_pressure_temp_compensation.sv
tb/baro_pressure_temp_compensation_tb.sv
